// ----- hw/rtl/i2cm_pkg.sv -----
// Shared types and codes for the I2C master bit engine.
package i2cm_pkg;

  // Command codes carried on s_tuser
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_STOP  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic {
    REG_PHASE_TICKS    = 1'b0,
    REG_ACK_POLL_LIMIT = 1'b1
  } reg_idx_t;

  localparam logic [15:0] PHASE_TICKS_RST    = 16'd100;
  localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd250;
  localparam int          DATA_BITS          = 8;

  // Pin sequencer steps
  typedef enum logic [4:0] {
    ST_IDLE     = 5'd0,
    ST_ST_A     = 5'd1,
    ST_ST_B     = 5'd2,
    ST_ST_C     = 5'd3,
    ST_SP_A     = 5'd4,
    ST_SP_B     = 5'd5,
    ST_SP_C     = 5'd6,
    ST_WR_D     = 5'd7,
    ST_WR_H     = 5'd8,
    ST_ACK_REL  = 5'd9,
    ST_ACK_H    = 5'd10,
    ST_ACK_POLL = 5'd11,
    ST_ACK_L    = 5'd12,
    ST_TO_A     = 5'd13,
    ST_TO_B     = 5'd14,
    ST_TO_C     = 5'd15,
    ST_TO_D     = 5'd16,
    ST_RD_H     = 5'd17,
    ST_RD_L     = 5'd18,
    ST_RK_D     = 5'd19,
    ST_RK_H     = 5'd20,
    ST_RK_L     = 5'd21,
    ST_RK_R     = 5'd22
  } step_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    func_t      func;
    logic [7:0] wr_data;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       no_ack;
    logic [7:0] rd_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } res_t;

endpackage

// ----- hw/rtl/i2c_master_bit_engine.sv -----
// Top level of the I2C master bit engine: config, stream ports, output register.
// Usage:
//   Slave channel (s_*): one transfer per bus clock tick. It carries the
//   sampled SDA level and, optionally, a command (cmd_valid set) picked by
//   s_tuser: start, stop, write byte, read byte. Commands seen while a
//   sequence runs are ignored.
//   Master channel (m_*): exactly one result transfer per input transfer,
//   holding the SCL/SDA drive levels, busy, done, last read byte and the
//   no-acknowledge flag as they stand after that tick.
//   Config port: cfg_we with cfg_index/cfg_wdata writes phase_ticks
//   (index 0) or ack_poll_limit (index 1, low 8 bits).
//   Write only while the engine is idle.
// Timing:
//   A result is registered and appears on m_* the cycle after its input
//   is taken. Throughput is one tick per cycle while m_* is not stalled;
//   the sequencer state and output register both update in the accept cycle.
// Reset (rst, synchronous): sequencer idle, both lines released, config
//   back to 100 ticks per phase and 250 polls, output register empty.
// Stall: when m_tready is low with a result pending, s_tready drops and
//   the held result stays until taken; no tick is lost or repeated.
module i2c_master_bit_engine
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // cmd_valid[0], wr_data[8:1], send_ack[9], sda_in[10]
  input  logic [1:0]  s_tuser,  // func[1:0]
  // master channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // scl_out[0], sda_out[1], busy_res[2], done_res[3],
                                // rd_data[11:4], no_ack[12]
  // config write port
  input  logic        cfg_we,
  input  reg_idx_t    cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t  cfg;
  tick_t tick;
  res_t  res;
  res_t  out_res;
  logic  take;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks    <= PHASE_TICKS_RST;
      cfg.ack_poll_limit <= ACK_POLL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_TICKS:    cfg.phase_ticks    <= cfg_wdata;
        REG_ACK_POLL_LIMIT: cfg.ack_poll_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // unpack the tick
  always_comb begin
    tick.cmd_valid = s_tdata[0];
    tick.func      = func_t'(s_tuser);
    tick.wr_data   = s_tdata[8:1];
    tick.send_ack  = s_tdata[9];
    tick.sda_in    = s_tdata[10];
  end

  // free output slot or the pending result leaves this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  i2cm_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (take),
    .cfg     (cfg),
    .tick    (tick),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res.no_ack, out_res.rd_data, out_res.done_res,
                    out_res.busy_res, out_res.sda_out, out_res.scl_out};

  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> m_tvalid)
    else $error("accepted tick produced no result");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.done_res |-> !out_res.busy_res)
    else $error("done result flagged busy");

endmodule

// ----- hw/rtl/i2cm_seq.sv -----
// Pin sequencer: advances the bus state by one tick per transfer.
module i2cm_seq
  import i2cm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step_en,
  input  cfg_t  cfg,
  input  tick_t tick,
  output res_t  res
);

  step_t       step, step_next;
  logic [15:0] wait_count, wait_count_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        ack_choice, ack_choice_next;
  logic        timeout_flag, timeout_flag_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic [7:0]  read_hold, read_hold_next;
  logic        done_now;
  logic [15:0] reload;
  logic [3:0]  bit_inc;

  // wait loaded on entering a step; zero length counts as one tick
  assign reload  = (cfg.phase_ticks == 16'd0) ? 16'd0 : cfg.phase_ticks - 16'd1;
  assign bit_inc = bit_index + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_IDLE;
      wait_count   <= '0;
      poll_count   <= '0;
      bit_index    <= '0;
      shift_byte   <= '0;
      ack_choice   <= 1'b0;
      timeout_flag <= 1'b0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
      read_hold    <= '0;
    end else if (step_en) begin
      step         <= step_next;
      wait_count   <= wait_count_next;
      poll_count   <= poll_count_next;
      bit_index    <= bit_index_next;
      shift_byte   <= shift_byte_next;
      ack_choice   <= ack_choice_next;
      timeout_flag <= timeout_flag_next;
      scl_level    <= scl_level_next;
      sda_level    <= sda_level_next;
      read_hold    <= read_hold_next;
    end
  end

  always_comb begin
    step_next         = step;
    wait_count_next   = wait_count;
    poll_count_next   = poll_count;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    ack_choice_next   = ack_choice;
    timeout_flag_next = timeout_flag;
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    read_hold_next    = read_hold;
    done_now          = 1'b0;

    if (step == ST_IDLE) begin
      if (tick.cmd_valid) begin
        wait_count_next = reload;
        unique case (tick.func)
          FUNC_START: begin
            sda_level_next = 1'b1;
            scl_level_next = 1'b1;
            step_next      = ST_ST_A;
          end
          FUNC_STOP: begin
            sda_level_next = 1'b0;
            step_next      = ST_SP_A;
          end
          FUNC_WRITE: begin
            shift_byte_next   = tick.wr_data;
            bit_index_next    = '0;
            timeout_flag_next = 1'b0;
            sda_level_next    = tick.wr_data[DATA_BITS-1];
            step_next         = ST_WR_D;
          end
          FUNC_READ: begin
            shift_byte_next = '0;
            bit_index_next  = '0;
            ack_choice_next = tick.send_ack;
            scl_level_next  = 1'b1;
            step_next       = ST_RD_H;
          end
          default: ;
        endcase
      end
    end else if (wait_count != 16'd0) begin
      wait_count_next = wait_count - 16'd1;
    end else begin
      wait_count_next = reload;
      unique case (step)
        ST_ST_A: begin sda_level_next = 1'b0; step_next = ST_ST_B; end
        ST_ST_B: begin scl_level_next = 1'b0; step_next = ST_ST_C; end
        ST_SP_A: begin scl_level_next = 1'b1; step_next = ST_SP_B; end
        ST_SP_B: begin sda_level_next = 1'b1; step_next = ST_SP_C; end
        ST_WR_D: begin scl_level_next = 1'b1; step_next = ST_WR_H; end
        ST_WR_H: begin
          scl_level_next  = 1'b0;
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_index_next  = bit_inc;
          if (bit_inc < 4'(DATA_BITS)) begin
            sda_level_next = shift_byte[6];
            step_next      = ST_WR_D;
          end else begin
            sda_level_next = 1'b1;
            step_next      = ST_ACK_REL;
          end
        end
        ST_ACK_REL: begin
          scl_level_next  = 1'b1;
          poll_count_next = '0;
          step_next       = ST_ACK_H;
        end
        ST_ACK_H, ST_ACK_POLL: begin
          if (!tick.sda_in) begin
            scl_level_next = 1'b0;
            step_next      = ST_ACK_L;
          end else if (poll_count >= cfg.ack_poll_limit) begin
            // no acknowledge in time: release with a STOP
            timeout_flag_next = 1'b1;
            sda_level_next    = 1'b0;
            step_next         = ST_TO_A;
          end else begin
            poll_count_next = poll_count + 8'd1;
            step_next       = ST_ACK_POLL;
          end
        end
        ST_TO_A: begin scl_level_next = 1'b1; step_next = ST_TO_B; end
        ST_TO_B: begin sda_level_next = 1'b1; step_next = ST_TO_C; end
        ST_TO_C: begin scl_level_next = 1'b0; step_next = ST_TO_D; end
        ST_RD_H: begin
          shift_byte_next = {shift_byte[6:0], tick.sda_in};
          scl_level_next  = 1'b0;
          bit_index_next  = bit_inc;
          step_next       = ST_RD_L;
        end
        ST_RD_L: begin
          if (bit_index < 4'(DATA_BITS)) begin
            scl_level_next = 1'b1;
            step_next      = ST_RD_H;
          end else begin
            read_hold_next = shift_byte;
            sda_level_next = !ack_choice;
            step_next      = ST_RK_D;
          end
        end
        ST_RK_D: begin scl_level_next = 1'b1; step_next = ST_RK_H; end
        ST_RK_H: begin scl_level_next = 1'b0; step_next = ST_RK_L; end
        ST_RK_L: begin
          if (ack_choice) begin
            sda_level_next = 1'b1;
            step_next      = ST_RK_R;
          end else begin
            step_next       = ST_IDLE;
            wait_count_next = '0;
            done_now        = 1'b1;
          end
        end
        default: begin
          // closing steps of each sequence, but a read sending no ack closes in ST_RK_L
          step_next       = ST_IDLE;
          wait_count_next = '0;
          done_now        = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_out  = scl_level_next;
    res.sda_out  = sda_level_next;
    res.busy_res = (step_next != ST_IDLE);
    res.done_res = done_now;
    res.rd_data  = read_hold_next;
    res.no_ack   = timeout_flag_next;
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    step_en && done_now |=> step == ST_IDLE)
    else $error("sequencer not idle after done");

  a_idle_no_wait: assert property (@(posedge clk) disable iff (rst)
    step == ST_IDLE |-> wait_count == 16'd0)
    else $error("wait count pending while idle");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= 4'(DATA_BITS))
    else $error("bit index past byte end");

endmodule
